// ===== design/fat16_root_directory_file_locator_macros.svh =====
// ----------------------------------------------------------------------------
// FAT16 root directory file locator: assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef FAT16_ROOT_DIRECTORY_FILE_LOCATOR_MACROS_SVH
`define FAT16_ROOT_DIRECTORY_FILE_LOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define FATL_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// condition must never hold
`define FATL_ASSERT_NEVER(lbl, ck, rstn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define FATL_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg)
`define FATL_ASSERT_NEVER(lbl, ck, rstn, cond, msg)
`endif
`endif

// ===== design/fatl_pkg.sv =====
// ----------------------------------------------------------------------------
// fatl_pkg
// Types and constants shared by the FAT16 root directory file locator.
// ----------------------------------------------------------------------------
`default_nettype none

package fatl_pkg;

  localparam int unsigned SECTOR_BYTES_DEF = 512;
  localparam int unsigned ENTRY_SHIFT      = 5;     // 32-byte directory entries
  localparam int unsigned CFG_INDEX_W      = 3;
  localparam int unsigned CFG_DATA_W       = 64;

  localparam logic [7:0]  MARK_DELETED = 8'hE5;
  localparam logic [7:0]  SKIP_ATTR    = 8'h18;
  localparam logic [7:0]  MARK_END     = 8'h00;
  localparam logic [31:0] CLUSTER_BASE = 32'd2;

  // register reset values
  localparam logic [15:0] RESERVED_SECTORS_RST = 16'd1;
  localparam logic [7:0]  FAT_COPIES_RST       = 8'd2;
  localparam logic [15:0] ROOT_ENTRIES_RST     = 16'd512;
  localparam logic [7:0]  CLUSTER_SECTORS_RST  = 8'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET_NAME      = 3'd0,
    REG_TARGET_EXT       = 3'd1,
    REG_PARTITION_START  = 3'd2,
    REG_RESERVED_SECTORS = 3'd3,
    REG_FAT_COPIES       = 3'd4,
    REG_SECTORS_PER_FAT  = 3'd5,
    REG_ROOT_ENTRIES     = 3'd6,
    REG_CLUSTER_SECTORS  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_SKIPPED    = 3'd0,
    ST_NO_MATCH   = 3'd1,
    ST_FOUND      = 3'd2,
    ST_END_MARKER = 3'd3,
    ST_DIR_FULL   = 3'd4,
    ST_FINISHED   = 3'd5
  } status_t;

  // layout and target as seen by the scan stage
  typedef struct packed {
    logic [63:0] target_name;
    logic [23:0] target_ext;
    logic [31:0] first_data_sector;
    logic [15:0] slot_count;
    logic [7:0]  cluster_sectors;
  } layout_t;

endpackage

`default_nettype wire

// ===== design/fatl_if.sv =====
// ----------------------------------------------------------------------------
// fatl_in_if / fatl_out_if
// Valid/ready channels for directory entries and lookup results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fatl_in_if;
  logic        valid;
  logic        ready;
  logic        new_scan;
  logic [63:0] entry_name;
  logic [23:0] entry_ext;
  logic [7:0]  entry_attributes;
  logic [15:0] start_cluster;
  logic [31:0] entry_file_size;

  modport source (output valid, new_scan, entry_name, entry_ext, entry_attributes,
                  start_cluster, entry_file_size, input ready);
  modport sink   (input valid, new_scan, entry_name, entry_ext, entry_attributes,
                  start_cluster, entry_file_size, output ready);
endinterface

interface fatl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] file_index;
  logic [31:0] start_sector;
  logic [31:0] file_size;

  modport source (output valid, status, file_index, start_sector, file_size,
                  input ready);
  modport sink   (input valid, status, file_index, start_sector, file_size,
                  output ready);
endinterface

`default_nettype wire

// ===== design/fat16_root_directory_file_locator.sv =====
// ----------------------------------------------------------------------------
// fat16_root_directory_file_locator
// Looks up one 8.3 file name among FAT16 root directory entries.
// ----------------------------------------------------------------------------
// Feed one 32-byte root directory entry per item, with new_scan set on the
// first entry of each lookup; every entry yields exactly one result. The
// block takes one entry per clock cycle while out_result is not held; an
// entry loads into the entry register when it is accepted, and its result
// loads into the result register once that register is free, after the
// single pass of compare, counter update and the cluster-to-sector
// multiply-add between those two registers. A result held on out_result keeps the entry
// behind it waiting, so at most two items are in the block. Derived layout
// values are registered from the configuration registers. SECTOR_BYTES must be a
// power of two from 512 to 4096. Once a scan has found its file, hit the end
// marker or run out of slots, every further entry answers "already finished"
// until new_scan is given again.
`default_nettype none

module fat16_root_directory_file_locator #(
  parameter int unsigned SECTOR_BYTES = fatl_pkg::SECTOR_BYTES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [fatl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fatl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  fatl_in_if.sink                               in_entry,
  fatl_out_if.source                            out_result
);

  fatl_pkg::layout_t layout;
  logic              scan_done;

  logic res_plain;
  logic res_open;
  logic res_closed;
  logic payload_zero;
  logic stall_empty;

  fatl_layout #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_layout (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .layout    (layout)
  );

  fatl_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .layout     (layout),
    .in_entry   (in_entry),
    .out_result (out_result),
    .scan_done  (scan_done)
  );

  assign res_plain    = out_result.valid && out_result.status != fatl_pkg::ST_FOUND;
  assign res_open     = out_result.valid &&
                        (out_result.status == fatl_pkg::ST_SKIPPED ||
                         out_result.status == fatl_pkg::ST_NO_MATCH);
  assign res_closed   = out_result.valid && !res_open;
  assign payload_zero = out_result.file_index == 16'd0 &&
                        out_result.start_sector == 32'd0 &&
                        out_result.file_size == 32'd0;
  assign stall_empty  = !out_result.valid && !in_entry.ready;

`include "fat16_root_directory_file_locator_macros.svh"

  // payload fields other than status are zero unless the file was found
  `FATL_ASSERT_IMP(a_payload_zero, clk, rst_n, res_plain, payload_zero, "stray payload")

  // a terminal or finished result leaves the scan closed
  `FATL_ASSERT_IMP(a_done_terminal, clk, rst_n, res_closed, scan_done, "scan still open")

  // a skipped or non-matching entry leaves the scan open
  `FATL_ASSERT_IMP(a_open_ongoing, clk, rst_n, res_open, !scan_done, "scan closed early")

  // an empty result register never holds back the input
  `FATL_ASSERT_NEVER(a_ready_when_empty, clk, rst_n, stall_empty, "input stalled while empty")

endmodule

`default_nettype wire

// ===== design/fatl_layout.sv =====
// ----------------------------------------------------------------------------
// fatl_layout
// Configuration registers and the derived volume layout (first data sector,
// root slot count), registered from the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fatl_layout #(
  parameter int unsigned SECTOR_BYTES = fatl_pkg::SECTOR_BYTES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [fatl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [fatl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output fatl_pkg::layout_t                       layout
);

  localparam int unsigned SectorShift = $clog2(SECTOR_BYTES);
  localparam int unsigned SlotShift   = SectorShift - fatl_pkg::ENTRY_SHIFT;
  localparam int unsigned RootBytesW  = 16 + fatl_pkg::ENTRY_SHIFT;

  logic [63:0] target_name_r;
  logic [23:0] target_ext_r;
  logic [31:0] partition_start_r;
  logic [15:0] reserved_sectors_r;
  logic [7:0]  fat_copies_r;
  logic [15:0] sectors_per_fat_r;
  logic [15:0] root_entries_r;
  logic [7:0]  cluster_sectors_r;

  logic [31:0] first_data_sector_r, first_data_sector_nxt;
  logic [15:0] slot_count_r, slot_count_nxt;

  logic [RootBytesW-1:0] root_bytes;
  logic [15:0]           root_sectors;
  logic [15:0]           slot_mask;
  logic [23:0]           fat_area;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_name_r      <= '0;
      target_ext_r       <= '0;
      partition_start_r  <= '0;
      reserved_sectors_r <= fatl_pkg::RESERVED_SECTORS_RST;
      fat_copies_r       <= fatl_pkg::FAT_COPIES_RST;
      sectors_per_fat_r  <= '0;
      root_entries_r     <= fatl_pkg::ROOT_ENTRIES_RST;
      cluster_sectors_r  <= fatl_pkg::CLUSTER_SECTORS_RST;
    end else if (cfg_we) begin
      unique case (fatl_pkg::cfg_reg_t'(cfg_index))
        fatl_pkg::REG_TARGET_NAME:      target_name_r      <= cfg_wdata;
        fatl_pkg::REG_TARGET_EXT:       target_ext_r       <= cfg_wdata[23:0];
        fatl_pkg::REG_PARTITION_START:  partition_start_r  <= cfg_wdata[31:0];
        fatl_pkg::REG_RESERVED_SECTORS: reserved_sectors_r <= cfg_wdata[15:0];
        fatl_pkg::REG_FAT_COPIES:       fat_copies_r       <= cfg_wdata[7:0];
        fatl_pkg::REG_SECTORS_PER_FAT:  sectors_per_fat_r  <= cfg_wdata[15:0];
        fatl_pkg::REG_ROOT_ENTRIES:     root_entries_r     <= cfg_wdata[15:0];
        fatl_pkg::REG_CLUSTER_SECTORS:  cluster_sectors_r  <= cfg_wdata[7:0];
      endcase
    end
  end

  // whole root directory sectors; slot count is that many sectors of entries
  assign root_bytes   = {root_entries_r, {fatl_pkg::ENTRY_SHIFT{1'b0}}};
  assign root_sectors = 16'(root_bytes >> SectorShift);
  assign slot_mask    = ~((16'd1 << SlotShift) - 16'd1);
  assign fat_area     = {16'd0, fat_copies_r} * {8'd0, sectors_per_fat_r};

  always_comb begin
    slot_count_nxt        = root_entries_r & slot_mask;
    first_data_sector_nxt = partition_start_r + {16'd0, reserved_sectors_r}
                          + {8'd0, fat_area} + {16'd0, root_sectors};
  end

  always_ff @(posedge clk) begin
    first_data_sector_r <= first_data_sector_nxt;
    slot_count_r        <= slot_count_nxt;
  end

  always_comb begin
    layout.target_name       = target_name_r;
    layout.target_ext        = target_ext_r;
    layout.first_data_sector = first_data_sector_r;
    layout.slot_count        = slot_count_r;
    layout.cluster_sectors   = cluster_sectors_r;
  end

endmodule

`default_nettype wire

// ===== design/fatl_scan.sv =====
// ----------------------------------------------------------------------------
// fatl_scan
// Entry input register, scan counters, entry classification and name
// compare, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fatl_scan (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fatl_pkg::layout_t layout,
  fatl_in_if.sink                in_entry,
  fatl_out_if.source             out_result,
  output logic                   scan_done
);

  typedef struct packed {
    logic        new_scan;
    logic [63:0] entry_name;
    logic [23:0] entry_ext;
    logic [7:0]  entry_attributes;
    logic [15:0] start_cluster;
    logic [31:0] entry_file_size;
  } entry_t;

  typedef struct packed {
    fatl_pkg::status_t status;
    logic [15:0]       file_index;
    logic [31:0]       start_sector;
    logic [31:0]       file_size;
  } result_t;

  logic    s1_valid_r;
  entry_t  s1_r;
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic [15:0] slots_seen_r, slots_seen_nxt;
  logic [15:0] valid_count_r, valid_count_nxt;
  logic        scan_done_r, scan_done_nxt;

  logic        advance;
  logic        in_ready;
  logic [7:0]  first_byte;
  logic [31:0] cluster_off;
  logic [31:0] cluster_prod;

  assign advance  = s1_valid_r && (!out_valid_r || out_result.ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_entry.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_entry.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_entry.valid) begin
      s1_r.new_scan         <= in_entry.new_scan;
      s1_r.entry_name       <= in_entry.entry_name;
      s1_r.entry_ext        <= in_entry.entry_ext;
      s1_r.entry_attributes <= in_entry.entry_attributes;
      s1_r.start_cluster    <= in_entry.start_cluster;
      s1_r.entry_file_size  <= in_entry.entry_file_size;
    end
  end

  // sector offset wraps modulo 2^32, as does the low-cluster subtraction
  assign first_byte   = s1_r.entry_name[63:56];
  assign cluster_off  = {16'd0, s1_r.start_cluster} - fatl_pkg::CLUSTER_BASE;
  assign cluster_prod = cluster_off * {24'd0, layout.cluster_sectors};

  always_comb begin
    slots_seen_nxt  = s1_r.new_scan ? 16'd0 : slots_seen_r;
    valid_count_nxt = s1_r.new_scan ? 16'd0 : valid_count_r;
    scan_done_nxt   = s1_r.new_scan ? 1'b0  : scan_done_r;
    res_nxt         = '0;
    priority if (scan_done_nxt) begin
      res_nxt.status = fatl_pkg::ST_FINISHED;
    end else if (slots_seen_nxt >= layout.slot_count) begin
      res_nxt.status = fatl_pkg::ST_DIR_FULL;
      scan_done_nxt  = 1'b1;
    end else if (first_byte == fatl_pkg::MARK_END) begin
      res_nxt.status = fatl_pkg::ST_END_MARKER;
      scan_done_nxt  = 1'b1;
    end else begin
      slots_seen_nxt = slots_seen_nxt + 16'd1;
      priority if (first_byte == fatl_pkg::MARK_DELETED ||
                   (s1_r.entry_attributes & fatl_pkg::SKIP_ATTR) != 8'd0) begin
        res_nxt.status = fatl_pkg::ST_SKIPPED;
      end else if (s1_r.entry_name == layout.target_name &&
                   s1_r.entry_ext == layout.target_ext) begin
        res_nxt.status       = fatl_pkg::ST_FOUND;
        res_nxt.file_index   = valid_count_nxt;
        res_nxt.start_sector = layout.first_data_sector + cluster_prod;
        res_nxt.file_size    = s1_r.entry_file_size;
        scan_done_nxt        = 1'b1;
      end else begin
        res_nxt.status  = fatl_pkg::ST_NO_MATCH;
        valid_count_nxt = valid_count_nxt + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_seen_r  <= '0;
      valid_count_r <= '0;
      scan_done_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (advance) begin
        slots_seen_r  <= slots_seen_nxt;
        valid_count_r <= valid_count_nxt;
        scan_done_r   <= scan_done_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_result.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_result.valid        = out_valid_r;
  assign out_result.status       = res_r.status;
  assign out_result.file_index   = res_r.file_index;
  assign out_result.start_sector = res_r.start_sector;
  assign out_result.file_size    = res_r.file_size;
  assign scan_done               = scan_done_r;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// FAT16 root directory file locator testbench
// Streams root directory entries through the locator and checks every
// lookup result against an in-bench scan predictor. The run covers directed
// corner entries, randomized scans over several volume layouts, and a long
// result-side hold that backs up the entry channel.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LOOKUP_SECTOR_BYTES = fatl_pkg::SECTOR_BYTES_DEF;
  localparam int unsigned DIR_ENTRY_BYTES     = 32;
  localparam int          HOLD_CYCLES         = 150;
  localparam int          STALL_LIMIT         = 2000;
  localparam int          SCAN_PHASES         = 8;
  localparam int          PHASE_ITEMS         = 125;

  typedef struct {
    bit          new_scan;
    logic [63:0] name;
    logic [23:0] ext;
    logic [7:0]  attr;
    logic [15:0] cluster;
    logic [31:0] size;
  } dir_entry_t;

  typedef struct {
    fatl_pkg::status_t status;
    logic [15:0]       file_index;
    logic [31:0]       start_sector;
    logic [31:0]       file_size;
  } lookup_t;

  typedef struct {
    logic [63:0] name;
    logic [23:0] ext;
    logic [31:0] part;
    logic [15:0] rsvd;
    logic [7:0]  fats;
    logic [15:0] spf;
    logic [15:0] roots;
    logic [7:0]  spc;
  } volume_layout_t;

  typedef enum int {
    KIND_FILE, KIND_DELETED, KIND_HIDDEN, KIND_TARGET, KIND_NEAR, KIND_END, KIND_NOISE
  } entry_kind_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [fatl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [fatl_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  fatl_in_if  entry_ch ();
  fatl_out_if result_ch ();

  fat16_root_directory_file_locator #(
    .SECTOR_BYTES(LOOKUP_SECTOR_BYTES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_entry   (entry_ch),
    .out_result (result_ch)
  );

  always #5 clk = ~clk;

  // layout as last written, and the scan counters as the block should hold them
  volume_layout_t layout_now = '{64'd0, 24'd0, 32'd0, fatl_pkg::RESERVED_SECTORS_RST,
                                 fatl_pkg::FAT_COPIES_RST, 16'd0,
                                 fatl_pkg::ROOT_ENTRIES_RST,
                                 fatl_pkg::CLUSTER_SECTORS_RST};
  logic [15:0] slots_used   = '0;
  logic [15:0] files_passed = '0;
  bit          scan_closed  = 1'b0;

  lookup_t pending_lookups[$];
  int      mismatches   = 0;
  int      quiet_cycles = 0;
  bit      tx_steady    = 1'b0;
  bit      rx_steady    = 1'b0;
  bit      hold_request = 1'b0;

  function automatic int pick_idle(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] root_sector_total();
    return ({16'd0, layout_now.roots} * DIR_ENTRY_BYTES) / LOOKUP_SECTOR_BYTES;
  endfunction

  function automatic logic [31:0] root_slot_total();
    return root_sector_total() * (LOOKUP_SECTOR_BYTES / DIR_ENTRY_BYTES);
  endfunction

  function automatic lookup_t predict_lookup(dir_entry_t e);
    lookup_t     r;
    logic [31:0] data_base;
    logic [7:0]  lead;
    r.status       = fatl_pkg::ST_SKIPPED;
    r.file_index   = '0;
    r.start_sector = '0;
    r.file_size    = '0;
    lead = e.name[63:56];
    if (e.new_scan) begin
      slots_used   = '0;
      files_passed = '0;
      scan_closed  = 1'b0;
    end
    if (scan_closed) begin
      r.status = fatl_pkg::ST_FINISHED;
    end else if ({16'd0, slots_used} >= root_slot_total()) begin
      r.status = fatl_pkg::ST_DIR_FULL;
      scan_closed = 1'b1;
    end else if (lead == fatl_pkg::MARK_END) begin
      r.status = fatl_pkg::ST_END_MARKER;
      scan_closed = 1'b1;
    end else begin
      slots_used = slots_used + 16'd1;
      if (lead == fatl_pkg::MARK_DELETED || (e.attr & fatl_pkg::SKIP_ATTR) != 8'd0) begin
        r.status = fatl_pkg::ST_SKIPPED;
      end else if (e.name == layout_now.name && e.ext == layout_now.ext) begin
        data_base = layout_now.part + {16'd0, layout_now.rsvd}
                  + {24'd0, layout_now.fats} * {16'd0, layout_now.spf}
                  + root_sector_total();
        r.status       = fatl_pkg::ST_FOUND;
        r.file_index   = files_passed;
        r.start_sector = data_base
                       + ({16'd0, e.cluster} - fatl_pkg::CLUSTER_BASE)
                         * {24'd0, layout_now.spc};
        r.file_size    = e.size;
        scan_closed    = 1'b1;
      end else begin
        r.status = fatl_pkg::ST_NO_MATCH;
        files_passed = files_passed + 16'd1;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    lookup_t want;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: result with none expected, expected nothing actual status %0d",
                 $time, result_ch.status);
        mismatches++;
      end else begin
        want = pending_lookups.pop_front();
        check_field("status", want.status, result_ch.status);
        check_field("file_index", want.file_index, result_ch.file_index);
        check_field("start_sector", want.start_sector, result_ch.start_sector);
        check_field("file_size", want.file_size, result_ch.file_size);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((entry_ch.valid && entry_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** fat16_root_directory_file_locator: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold on request
  initial begin : result_sink
    int stall;
    stall = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_idle(rx_steady);
        result_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  task automatic send_entry(dir_entry_t e);
    int gap;
    gap = pick_idle(tx_steady);
    if (gap > 0) begin
      entry_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    entry_ch.valid            <= 1'b1;
    entry_ch.new_scan         <= e.new_scan;
    entry_ch.entry_name       <= e.name;
    entry_ch.entry_ext        <= e.ext;
    entry_ch.entry_attributes <= e.attr;
    entry_ch.start_cluster    <= e.cluster;
    entry_ch.entry_file_size  <= e.size;
    do @(posedge clk); while (entry_ch.ready !== 1'b1);
    pending_lookups.push_back(predict_lookup(e));
  endtask

  // drop valid and hold until every outstanding lookup has come back
  task automatic await_drain();
    entry_ch.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(fatl_pkg::cfg_reg_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_layout(volume_layout_t v);
    await_drain();
    write_reg(fatl_pkg::REG_TARGET_NAME, v.name);
    write_reg(fatl_pkg::REG_TARGET_EXT, {40'd0, v.ext});
    write_reg(fatl_pkg::REG_PARTITION_START, {32'd0, v.part});
    write_reg(fatl_pkg::REG_RESERVED_SECTORS, {48'd0, v.rsvd});
    write_reg(fatl_pkg::REG_FAT_COPIES, {56'd0, v.fats});
    write_reg(fatl_pkg::REG_SECTORS_PER_FAT, {48'd0, v.spf});
    write_reg(fatl_pkg::REG_ROOT_ENTRIES, {48'd0, v.roots});
    write_reg(fatl_pkg::REG_CLUSTER_SECTORS, {56'd0, v.spc});
    cfg_we <= 1'b0;
    layout_now = v;
  endtask

  // space-padded 8.3 field, first character in the top byte
  function automatic logic [63:0] pad_field(string s, int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++)
      v[(n-1-i)*8 +: 8] = (i < s.len()) ? s[i] : 8'h20;
    return v;
  endfunction

  function automatic logic [63:0] rand_padded(int n);
    logic [63:0] v;
    int          used;
    v = '0;
    used = $urandom_range(1, n);
    for (int i = 0; i < n; i++)
      v[(n-1-i)*8 +: 8] = (i < used) ? 8'h41 + 8'($urandom_range(0, 25)) : 8'h20;
    return v;
  endfunction

  function automatic dir_entry_t dir_entry(bit ns, logic [63:0] nm, logic [23:0] ex,
                                           logic [7:0] at, logic [15:0] cl, logic [31:0] sz);
    dir_entry_t e;
    e.new_scan = ns;
    e.name     = nm;
    e.ext      = ex;
    e.attr     = at;
    e.cluster  = cl;
    e.size     = sz;
    return e;
  endfunction

  function automatic entry_kind_t choose_kind(bit open_ended);
    int r;
    r = $urandom_range(0, 99);
    if (open_ended) begin
      if (r < 50) return KIND_FILE;
      if (r < 65) return KIND_DELETED;
      if (r < 80) return KIND_HIDDEN;
      return KIND_NEAR;
    end
    if (r < 40) return KIND_FILE;
    if (r < 50) return KIND_DELETED;
    if (r < 60) return KIND_HIDDEN;
    if (r < 70) return KIND_TARGET;
    if (r < 82) return KIND_NEAR;
    if (r < 90) return KIND_END;
    return KIND_NOISE;
  endfunction

  function automatic dir_entry_t make_entry(entry_kind_t kind, bit ns);
    dir_entry_t e;
    int         r;
    int         pos;
    logic [7:0] flip;
    r = $urandom_range(0, 9);
    e = dir_entry(ns, {$urandom, $urandom}, 24'($urandom), 8'($urandom), 16'($urandom),
                  (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom));
    if ($urandom_range(0, 1)) e.name = rand_padded(8);
    case (kind)
      KIND_FILE: begin
        if (e.name[63:56] == fatl_pkg::MARK_END || e.name[63:56] == fatl_pkg::MARK_DELETED)
          e.name[63:56] = 8'h41 + 8'($urandom_range(0, 25));
        e.attr &= ~fatl_pkg::SKIP_ATTR;
      end
      KIND_DELETED: begin
        if ($urandom_range(0, 1)) begin
          e.name = layout_now.name;
          e.ext  = layout_now.ext;
        end
        e.name[63:56] = fatl_pkg::MARK_DELETED;
      end
      KIND_HIDDEN: begin
        if ($urandom_range(0, 1)) begin
          e.name = layout_now.name;
          e.ext  = layout_now.ext;
        end
        if (e.name[63:56] == fatl_pkg::MARK_END) e.name[63:56] = 8'h5F;
        e.attr |= ($urandom_range(0, 2) == 0) ? 8'h08 :
                  ($urandom_range(0, 1) ? 8'h10 : fatl_pkg::SKIP_ATTR);
      end
      KIND_TARGET: begin
        e.name = layout_now.name;
        e.ext  = layout_now.ext;
        e.attr &= ~fatl_pkg::SKIP_ATTR;
      end
      KIND_NEAR: begin
        e.name = layout_now.name;
        e.ext  = layout_now.ext;
        e.attr &= ~fatl_pkg::SKIP_ATTR;
        pos  = $urandom_range(0, 10);
        flip = 8'($urandom_range(1, 255));
        if (pos < 8) e.name[(7-pos)*8 +: 8] ^= flip;
        else e.ext[(10-pos)*8 +: 8] ^= flip;
      end
      KIND_END: e.name[63:56] = fatl_pkg::MARK_END;
      default: ;
    endcase
    return e;
  endfunction

  task automatic load_random_layout();
    volume_layout_t v;
    int             r;
    v.name  = ($urandom_range(0, 99) < 75) ? rand_padded(8) : {$urandom, $urandom};
    v.ext   = ($urandom_range(0, 99) < 75) ? 24'(rand_padded(3)) : 24'($urandom);
    v.part  = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
    v.rsvd  = 16'($urandom);
    v.fats  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
    v.spf   = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 60) v.roots = 16'($urandom_range(16, 96));
    else if (r < 75) v.roots = 16'($urandom_range(0, 15));
    else if (r < 90) v.roots = 16'($urandom);
    else v.roots = 16'hFFFF;
    r = $urandom_range(0, 99);
    if (r < 70) v.spc = 8'(1 << $urandom_range(0, 7));
    else if (r < 85) v.spc = 8'd0;
    else v.spc = 8'($urandom);
    load_layout(v);
  endtask

  // one scan: mostly a well-formed run from a new_scan entry onward; some
  // scans carry no terminator so they run out of directory slots
  task automatic run_scan(output int n_items);
    logic [31:0] slots;
    bit          open_ended;
    bit          ns;
    int          span;
    slots = root_slot_total();
    open_ended = ($urandom_range(0, 99) < 25) && (slots <= 40);
    tx_steady  = ($urandom_range(0, 99) < 15);
    rx_steady  = tx_steady;
    span = open_ended ? int'(slots) + $urandom_range(1, 3) : $urandom_range(1, 30);
    for (int i = 0; i < span; i++) begin
      ns = (i == 0) ? ($urandom_range(0, 99) < 95) : ($urandom_range(0, 99) < 2);
      send_entry(make_entry(choose_kind(open_ended), ns));
    end
    n_items = span;
  endtask

  task automatic test_reset_layout();
    send_entry(dir_entry(1'b1, pad_field("KERNEL", 8), 24'(pad_field("SYS", 3)),
                         8'h20, 16'd2, 32'd100));
    send_entry(dir_entry(1'b0, {fatl_pkg::MARK_DELETED, 56'h0}, 24'h0, 8'h00, 16'd3, 32'd1));
    send_entry(dir_entry(1'b0, pad_field("SUBDIR", 8), 24'(pad_field("", 3)),
                         8'h10, 16'd4, 32'd0));
    send_entry(dir_entry(1'b0, 64'h0, 24'h0, 8'h00, 16'd0, 32'd0));
    send_entry(dir_entry(1'b0, pad_field("LATE", 8), 24'(pad_field("BIN", 3)),
                         8'h00, 16'd9, 32'd9));
  endtask

  task automatic test_directed_lookup();
    volume_layout_t v;
    logic [63:0]    nm;
    logic [23:0]    ex;
    nm = pad_field("README", 8);
    ex = 24'(pad_field("TXT", 3));
    v = '{nm, ex, 32'h0000_0800, 16'd4, 8'd2, 16'd250, 16'd512, 8'd4};
    load_layout(v);
    send_entry(dir_entry(1'b1, nm, 24'(pad_field("TXB", 3)), 8'h20, 16'd7, 32'd5));
    send_entry(dir_entry(1'b0, pad_field("README1", 8), ex, 8'h00, 16'd8, 32'd6));
    // deleted copy of the target
    send_entry(dir_entry(1'b0, {fatl_pkg::MARK_DELETED, nm[55:0]}, ex, 8'h00, 16'd9, 32'd7));
    send_entry(dir_entry(1'b0, nm, ex, 8'h10, 16'd10, 32'd8));
    send_entry(dir_entry(1'b0, nm, ex, 8'h08, 16'd11, 32'd9));
    send_entry(dir_entry(1'b0, nm, ex, 8'h27, 16'd0, 32'hFFFF_FFFF));
    send_entry(dir_entry(1'b0, nm, ex, 8'h00, 16'd12, 32'd10));
    send_entry(dir_entry(1'b1, nm, ex, 8'h01, 16'd1, 32'd0));
    send_entry(dir_entry(1'b1, 64'h0, ex, 8'h00, 16'd5, 32'd5));
    send_entry(dir_entry(1'b1, nm, ex, 8'hC0, 16'hFFFF, 32'd1234));

    // fewer than one sector of entries leaves no slots at all
    v.roots = 16'd15;
    load_layout(v);
    send_entry(dir_entry(1'b1, nm, ex, 8'h00, 16'd5, 32'd5));
    send_entry(dir_entry(1'b0, nm, ex, 8'h00, 16'd5, 32'd5));

    v = '{'1, '1, '1, '1, '1, '1, '1, '1};
    load_layout(v);
    send_entry(dir_entry(1'b1, '1, '1, 8'h00, 16'd0, 32'd77));
    send_entry(dir_entry(1'b1, '1, '1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_entry(dir_entry(1'b1, '1, '1, 8'hE7, 16'hFFFF, 32'hFFFF_FFFF));

    v = '{pad_field("A", 8), 24'(pad_field("", 3)), 32'd0, 16'd0, 8'd0, 16'd0, 16'd16, 8'd0};
    load_layout(v);
    send_entry(dir_entry(1'b1, pad_field("B", 8), v.ext, 8'h00, 16'd5, 32'd1));
    send_entry(dir_entry(1'b0, v.name, v.ext, 8'h00, 16'd5, 32'd2));
    send_entry(dir_entry(1'b1, v.name, v.ext, 8'h00, 16'd1, 32'd3));
  endtask

  task automatic test_random_scans();
    int count;
    int n;
    for (int phase = 0; phase < SCAN_PHASES; phase++) begin
      load_random_layout();
      count = 0;
      while (count < PHASE_ITEMS) begin
        run_scan(n);
        count += n;
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // hold results off while entries keep coming, so the block backs up
  task automatic test_backpressure();
    tx_steady = 1'b1;
    rx_steady = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++)
      send_entry(make_entry(choose_kind(1'b0), (i == 0) || ($urandom_range(0, 9) == 0)));
    tx_steady = 1'b0;
  endtask

  initial begin : run_tests
    entry_ch.valid            = 1'b0;
    entry_ch.new_scan         = 1'b0;
    entry_ch.entry_name       = '0;
    entry_ch.entry_ext        = '0;
    entry_ch.entry_attributes = '0;
    entry_ch.start_cluster    = '0;
    entry_ch.entry_file_size  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_layout();
    test_directed_lookup();
    test_random_scans();
    test_backpressure();

    await_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("** fat16_root_directory_file_locator: PASSED **");
    else
      $display("** fat16_root_directory_file_locator: FAILED **");
    $finish;
  end

endmodule
